// ===== hw/rtl/lmt_pkg.sv =====
// ----------------------------------------------------------------------------
// lmt_pkg: shared types and constants of the local mean threshold unit
// pixel width, derived sum and count widths, and the result item type
// ----------------------------------------------------------------------------
package lmt_pkg;

    localparam int PIXEL_BITS   = 8;
    // in-bounds sum of one column slice (up to three pixels)
    localparam int COLSUM_BITS  = PIXEL_BITS + 2;
    // in-bounds sum of the whole 3x3 window (up to nine pixels)
    localparam int WINSUM_BITS  = PIXEL_BITS + 4;
    // pixels in one column slice (1..3)
    localparam int ROWS_BITS    = 2;
    // pixels in the window (1..9)
    localparam int COUNT_BITS   = 4;
    // product of a centre pixel and a window count
    localparam int PROD_BITS    = PIXEL_BITS + COUNT_BITS;

    localparam int S_TDATA_BITS = ((3 * PIXEL_BITS + 7) / 8) * 8;
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 8;

    // tuser bit positions on the input side
    localparam int TUSER_HAS_ABOVE = 0;
    localparam int TUSER_HAS_BELOW = 1;

    localparam int QUEUE_DEPTH  = 3;
    localparam int QCOUNT_BITS  = 2;

    typedef struct packed {
        logic binary_out;
        logic last_of_row;
    } result_t;

    // results produced by one accepted column slice
    typedef struct packed {
        logic [1:0] push_count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

// ===== hw/rtl/lmt_window.sv =====
// ----------------------------------------------------------------------------
// lmt_window: column history and threshold decision
// keeps two previous column sums and the previous centre, emits up to two
// results for each accepted column slice
// ----------------------------------------------------------------------------
module lmt_window (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic [lmt_pkg::PIXEL_BITS-1:0]      pixel_above,
    input  logic [lmt_pkg::PIXEL_BITS-1:0]      pixel_center,
    input  logic [lmt_pkg::PIXEL_BITS-1:0]      pixel_below,
    input  logic                                has_above,
    input  logic                                has_below,
    input  logic                                row_end,
    output lmt_pkg::result_pair_t               results
);

    logic [lmt_pkg::COLSUM_BITS-1:0] colsum_two_back_reg, colsum_two_back_next;
    logic [lmt_pkg::COLSUM_BITS-1:0] colsum_one_back_reg, colsum_one_back_next;
    logic [lmt_pkg::PIXEL_BITS-1:0]  center_one_back_reg, center_one_back_next;
    logic [lmt_pkg::ROWS_BITS-1:0]   rows_two_back_reg, rows_two_back_next;
    logic [lmt_pkg::ROWS_BITS-1:0]   rows_one_back_reg, rows_one_back_next;
    logic                            have_one_back_reg, have_one_back_next;
    logic                            have_two_back_reg, have_two_back_next;

    logic [lmt_pkg::COLSUM_BITS-1:0] cur_sum;
    logic [lmt_pkg::ROWS_BITS-1:0]   cur_rows;
    logic [lmt_pkg::WINSUM_BITS-1:0] mid_sum, end_sum;
    logic [lmt_pkg::COUNT_BITS-1:0]  mid_count, end_count;
    logic [lmt_pkg::PROD_BITS-1:0]   mid_prod, end_prod;
    logic                            mid_bit, end_bit;
    lmt_pkg::result_t                mid_res, end_res;

    always_comb begin
        cur_sum  = lmt_pkg::COLSUM_BITS'(pixel_center)
                 + (has_above ? lmt_pkg::COLSUM_BITS'(pixel_above) : '0)
                 + (has_below ? lmt_pkg::COLSUM_BITS'(pixel_below) : '0);
        cur_rows = lmt_pkg::ROWS_BITS'(1) + lmt_pkg::ROWS_BITS'(has_above)
                 + lmt_pkg::ROWS_BITS'(has_below);

        // window around the previous column
        mid_sum   = lmt_pkg::WINSUM_BITS'(colsum_one_back_reg)
                  + lmt_pkg::WINSUM_BITS'(cur_sum)
                  + (have_two_back_reg ? lmt_pkg::WINSUM_BITS'(colsum_two_back_reg) : '0);
        mid_count = lmt_pkg::COUNT_BITS'(rows_one_back_reg)
                  + lmt_pkg::COUNT_BITS'(cur_rows)
                  + (have_two_back_reg ? lmt_pkg::COUNT_BITS'(rows_two_back_reg) : '0);
        mid_prod  = lmt_pkg::PROD_BITS'(center_one_back_reg) * lmt_pkg::PROD_BITS'(mid_count);
        mid_bit   = lmt_pkg::WINSUM_BITS'(mid_prod) > mid_sum;

        // window around the last column, right neighbor missing
        end_sum   = lmt_pkg::WINSUM_BITS'(cur_sum)
                  + (have_one_back_reg ? lmt_pkg::WINSUM_BITS'(colsum_one_back_reg) : '0);
        end_count = lmt_pkg::COUNT_BITS'(cur_rows)
                  + (have_one_back_reg ? lmt_pkg::COUNT_BITS'(rows_one_back_reg) : '0);
        end_prod  = lmt_pkg::PROD_BITS'(pixel_center) * lmt_pkg::PROD_BITS'(end_count);
        end_bit   = lmt_pkg::WINSUM_BITS'(end_prod) > end_sum;

        mid_res.binary_out  = mid_bit;
        mid_res.last_of_row = 1'b0;
        end_res.binary_out  = end_bit;
        end_res.last_of_row = 1'b1;

        results.push_count = 2'(have_one_back_reg) + 2'(row_end);
        results.first      = have_one_back_reg ? mid_res : end_res;
        results.second     = end_res;
    end

    always_comb begin
        colsum_two_back_next = colsum_two_back_reg;
        colsum_one_back_next = colsum_one_back_reg;
        center_one_back_next = center_one_back_reg;
        rows_two_back_next   = rows_two_back_reg;
        rows_one_back_next   = rows_one_back_reg;
        have_one_back_next   = have_one_back_reg;
        have_two_back_next   = have_two_back_reg;
        if (accept) begin
            if (row_end) begin
                colsum_two_back_next = '0;
                colsum_one_back_next = '0;
                center_one_back_next = '0;
                rows_two_back_next   = '0;
                rows_one_back_next   = '0;
                have_one_back_next   = 1'b0;
                have_two_back_next   = 1'b0;
            end else begin
                colsum_two_back_next = colsum_one_back_reg;
                rows_two_back_next   = rows_one_back_reg;
                have_two_back_next   = have_one_back_reg;
                colsum_one_back_next = cur_sum;
                rows_one_back_next   = cur_rows;
                center_one_back_next = pixel_center;
                have_one_back_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colsum_two_back_reg <= '0;
            colsum_one_back_reg <= '0;
            center_one_back_reg <= '0;
            rows_two_back_reg   <= '0;
            rows_one_back_reg   <= '0;
            have_one_back_reg   <= 1'b0;
            have_two_back_reg   <= 1'b0;
        end else begin
            colsum_two_back_reg <= colsum_two_back_next;
            colsum_one_back_reg <= colsum_one_back_next;
            center_one_back_reg <= center_one_back_next;
            rows_two_back_reg   <= rows_two_back_next;
            rows_one_back_reg   <= rows_one_back_next;
            have_one_back_reg   <= have_one_back_next;
            have_two_back_reg   <= have_two_back_next;
        end
    end

endmodule

// ===== hw/rtl/lmt_out_queue.sv =====
// ----------------------------------------------------------------------------
// lmt_out_queue: three-entry result register queue
// takes up to two results a cycle, hands out one, head entry drives the port
// ----------------------------------------------------------------------------
module lmt_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lmt_pkg::result_pair_t results,
    output logic                  room,
    output logic                  head_valid,
    output lmt_pkg::result_t      head,
    input  logic                  pop
);

    lmt_pkg::result_t                entry_reg  [lmt_pkg::QUEUE_DEPTH];
    lmt_pkg::result_t                entry_next [lmt_pkg::QUEUE_DEPTH];
    logic [lmt_pkg::QCOUNT_BITS-1:0] count_reg, count_next;
    logic [lmt_pkg::QCOUNT_BITS-1:0] base;
    logic [lmt_pkg::QCOUNT_BITS-1:0] push_n;
    logic                            do_pop;

    // room for two results whatever the sink does
    assign room       = count_reg <= lmt_pkg::QCOUNT_BITS'(1);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[0];

    always_comb begin
        do_pop = pop && head_valid;
        push_n = push ? results.push_count : '0;
        base   = count_reg - lmt_pkg::QCOUNT_BITS'(do_pop);
        for (int i = 0; i < lmt_pkg::QUEUE_DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
        end
        // shift toward the head on a pop
        if (do_pop) begin
            for (int i = 0; i < lmt_pkg::QUEUE_DEPTH - 1; i++) begin
                entry_next[i] = entry_reg[i + 1];
            end
        end
        for (int i = 0; i < lmt_pkg::QUEUE_DEPTH; i++) begin
            if (push_n != '0 && lmt_pkg::QCOUNT_BITS'(i) == base) begin
                entry_next[i] = results.first;
            end
            if (push_n == 2'd2 && lmt_pkg::QCOUNT_BITS'(i) == base + 2'd1) begin
                entry_next[i] = results.second;
            end
        end
        count_next = base + push_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < lmt_pkg::QUEUE_DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

endmodule

// ===== hw/rtl/local_mean_threshold_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// local_mean_threshold_3x3_unit: 3x3 local mean binarizer
// streams column slices in, one thresholded pixel per result out
// ----------------------------------------------------------------------------
// usage
//   the slave channel takes one column slice per transaction: the pixels
//   above, at and below the current row, with tuser flags telling whether
//   the rows above and below exist and tlast on the last column of a row
//   the master channel gives one result per transaction: the binary pixel in
//   tdata bit 0 and tlast on the result for the last column of a row
//   a pixel needs its right neighbor, so the result for a column leaves with the
//   next column's transaction; the last column of a multi-column row gives two
//   the results that a slice completes are written into the output queue
//   registers when the slice is taken; m_tvalid shows the queue head
//   throughput: one slice per cycle while the queue has room, set by the single
//   pass through the window adder and compare; after the last column of a row
//   of two or more columns s_tready drops until the first of its two results
//   has left; a single-column row does not drop s_tready
//   reset clears the column history, so the first slice starts a row
//   when the receiver stalls, up to three results wait in the output queue
//   and s_tready drops once two or more are pending
// ----------------------------------------------------------------------------
module local_mean_threshold_3x3_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // pixel_above, pixel_center, pixel_below from bit 0 up
    input  logic [lmt_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // has_above, has_below from bit 0 up
    input  logic [lmt_pkg::S_TUSER_BITS-1:0]  s_tuser,
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // binary_out in bit 0, rest zero
    output logic [lmt_pkg::M_TDATA_BITS-1:0]  m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready
);

    localparam int PB = lmt_pkg::PIXEL_BITS;

    logic                  accept;
    lmt_pkg::result_pair_t results;
    lmt_pkg::result_t      head;
    logic                  room;

    // a transaction on the slave side
    assign accept   = s_tvalid && s_tready;
    assign s_tready = room;

    // history update and decisions for the incoming slice
    lmt_window u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .pixel_above  (s_tdata[PB-1:0]),
        .pixel_center (s_tdata[2*PB-1:PB]),
        .pixel_below  (s_tdata[3*PB-1:2*PB]),
        .has_above    (s_tuser[lmt_pkg::TUSER_HAS_ABOVE]),
        .has_below    (s_tuser[lmt_pkg::TUSER_HAS_BELOW]),
        .row_end      (s_tlast),
        .results      (results)
    );

    // result registers in front of the master port
    lmt_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .results    (results),
        .room       (room),
        .head_valid (m_tvalid),
        .head       (head),
        .pop        (m_tready)
    );

    assign m_tdata = lmt_pkg::M_TDATA_BITS'(head.binary_out);
    assign m_tlast = head.last_of_row;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the 3x3 local mean threshold unit
// column slices go in row by row, with directed border and flag cases first,
// then random rows; each thresholded pixel that comes out is checked against
// a scoreboard that tracks the column history and the expected results
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned SLICE_TARGET   = 900;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef logic [lmt_pkg::PIXEL_BITS-1:0]  pixel_t;
    typedef logic [lmt_pkg::COLSUM_BITS-1:0] colsum_t;
    typedef logic [lmt_pkg::WINSUM_BITS-1:0] winsum_t;
    typedef logic [lmt_pkg::COUNT_BITS-1:0]  count_t;
    typedef logic [lmt_pkg::ROWS_BITS-1:0]   rows_t;

    typedef struct {
        pixel_t above;
        pixel_t center;
        pixel_t below;
        logic   has_above;
        logic   has_below;
        logic   row_end;
    } slice_t;

    typedef enum {PIX_ANY, PIX_FLAT, PIX_EXTREME} pixel_style_t;

    class threshold_scoreboard;
        colsum_t          sum_two_back;
        colsum_t          sum_one_back;
        rows_t            rows_two_back;
        rows_t            rows_one_back;
        pixel_t           center_prev;
        bit               have_prev;
        bit               have_prev2;
        lmt_pkg::result_t expected_q[$];
        int unsigned      slices_taken;
        int unsigned      fail_count;

        function new();
            clear_history();
            slices_taken = 0;
            fail_count   = 0;
        endfunction

        function void clear_history();
            sum_two_back  = '0;
            sum_one_back  = '0;
            rows_two_back = '0;
            rows_one_back = '0;
            center_prev   = '0;
            have_prev     = 1'b0;
            have_prev2    = 1'b0;
        endfunction

        // exact form of center > mean: center * count > sum
        function logic above_mean(pixel_t center, winsum_t sum, count_t count);
            logic [lmt_pkg::PROD_BITS-1:0] prod;
            prod = lmt_pkg::PROD_BITS'(center) * lmt_pkg::PROD_BITS'(count);
            return prod > sum;
        endfunction

        function void note_slice(slice_t s);
            colsum_t          cur_sum;
            rows_t            cur_rows;
            winsum_t          win_sum;
            count_t           win_count;
            lmt_pkg::result_t r;
            slices_taken++;
            cur_sum  = lmt_pkg::COLSUM_BITS'(s.center);
            cur_rows = lmt_pkg::ROWS_BITS'(1);
            if (s.has_above) begin
                cur_sum  = cur_sum + lmt_pkg::COLSUM_BITS'(s.above);
                cur_rows = cur_rows + lmt_pkg::ROWS_BITS'(1);
            end
            if (s.has_below) begin
                cur_sum  = cur_sum + lmt_pkg::COLSUM_BITS'(s.below);
                cur_rows = cur_rows + lmt_pkg::ROWS_BITS'(1);
            end
            // previous column is completed by this one
            if (have_prev) begin
                win_sum   = lmt_pkg::WINSUM_BITS'(sum_one_back)
                          + lmt_pkg::WINSUM_BITS'(cur_sum);
                win_count = lmt_pkg::COUNT_BITS'(rows_one_back)
                          + lmt_pkg::COUNT_BITS'(cur_rows);
                if (have_prev2) begin
                    win_sum   = win_sum + lmt_pkg::WINSUM_BITS'(sum_two_back);
                    win_count = win_count + lmt_pkg::COUNT_BITS'(rows_two_back);
                end
                r.binary_out  = above_mean(center_prev, win_sum, win_count);
                r.last_of_row = 1'b0;
                expected_q.push_back(r);
            end
            if (s.row_end) begin
                win_sum   = lmt_pkg::WINSUM_BITS'(cur_sum);
                win_count = lmt_pkg::COUNT_BITS'(cur_rows);
                if (have_prev) begin
                    win_sum   = win_sum + lmt_pkg::WINSUM_BITS'(sum_one_back);
                    win_count = win_count + lmt_pkg::COUNT_BITS'(rows_one_back);
                end
                r.binary_out  = above_mean(s.center, win_sum, win_count);
                r.last_of_row = 1'b1;
                expected_q.push_back(r);
                clear_history();
            end else begin
                sum_two_back  = sum_one_back;
                rows_two_back = rows_one_back;
                have_prev2    = have_prev;
                sum_one_back  = cur_sum;
                rows_one_back = cur_rows;
                center_prev   = s.center;
                have_prev     = 1'b1;
            end
        endfunction

        function void check_result(logic binary_out, logic last_of_row);
            lmt_pkg::result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: binary_out %0d last_of_row %0d",
                       binary_out, last_of_row);
                fail_count++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (binary_out !== exp_r.binary_out) begin
                $error("binary_out: expected %0d, got %0d", exp_r.binary_out, binary_out);
                fail_count++;
            end
            if (last_of_row !== exp_r.last_of_row) begin
                $error("last_of_row: expected %0d, got %0d", exp_r.last_of_row, last_of_row);
                fail_count++;
            end
        endfunction
    endclass

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic [lmt_pkg::S_TDATA_BITS-1:0]  s_tdata  = '0;
    logic [lmt_pkg::S_TUSER_BITS-1:0]  s_tuser  = '0;
    logic                              s_tlast  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [lmt_pkg::M_TDATA_BITS-1:0]  m_tdata;
    logic                              m_tlast;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;

    threshold_scoreboard sb = new();
    bit                  sender_may_idle = 1'b1;
    int unsigned         idle_cycles = 0;

    local_mean_threshold_3x3_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // mostly short pauses, a few long ones
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic int unsigned sender_gap();
        if (!sender_may_idle || $urandom_range(0, 99) < 55) return 0;
        return pause_len();
    endfunction

    function automatic pixel_t pick_pixel(pixel_style_t style, pixel_t base);
        int v;
        case (style)
            PIX_FLAT: begin
                v = int'(base) + int'($urandom_range(0, 4)) - 2;
                if (v < 0) v = 0;
                if (v > (1 << lmt_pkg::PIXEL_BITS) - 1) v = (1 << lmt_pkg::PIXEL_BITS) - 1;
                return pixel_t'(v);
            end
            PIX_EXTREME: begin
                return $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                return pixel_t'($urandom_range(0, (1 << lmt_pkg::PIXEL_BITS) - 1));
            end
        endcase
    endfunction

    task automatic send_slice(input slice_t s);
        logic [lmt_pkg::S_TUSER_BITS-1:0] flags;
        int unsigned                      gap;
        flags = '0;
        flags[lmt_pkg::TUSER_HAS_ABOVE] = s.has_above;
        flags[lmt_pkg::TUSER_HAS_BELOW] = s.has_below;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata  <= lmt_pkg::S_TDATA_BITS'({s.below, s.center, s.above});
        s_tuser  <= flags;
        s_tlast  <= s.row_end;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_slice(s);
    endtask

    task automatic send_fixed(input pixel_t a, input pixel_t c, input pixel_t b,
                              input logic up, input logic down, input logic last);
        slice_t s;
        s.above     = a;
        s.center    = c;
        s.below     = b;
        s.has_above = up;
        s.has_below = down;
        s.row_end   = last;
        send_slice(s);
    endtask

    task automatic send_random_row();
        int unsigned  len;
        pixel_style_t style;
        pixel_t       base;
        bit           flags_per_slice;
        logic         up;
        logic         down;
        slice_t       s;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        case ($urandom_range(0, 3))
            0:       style = PIX_FLAT;
            1:       style = PIX_EXTREME;
            default: style = PIX_ANY;
        endcase
        base            = pixel_t'($urandom_range(0, (1 << lmt_pkg::PIXEL_BITS) - 1));
        flags_per_slice = ($urandom_range(0, 9) < 3);
        up              = 1'($urandom_range(0, 1));
        down            = 1'($urandom_range(0, 1));
        sender_may_idle = ($urandom_range(0, 9) >= 3);
        for (int unsigned col = 0; col < len; col++) begin
            if (flags_per_slice) begin
                up   = 1'($urandom_range(0, 1));
                down = 1'($urandom_range(0, 1));
            end
            s.above     = pick_pixel(style, base);
            s.center    = pick_pixel(style, base);
            s.below     = pick_pixel(style, base);
            s.has_above = up;
            s.has_below = down;
            s.row_end   = (col == len - 1);
            send_slice(s);
        end
    endtask

    // receiver: stretches of steady acceptance mixed with random stalls
    initial begin
        int unsigned seg;
        bit          steady;
        int unsigned stall;
        stall = 0;
        forever begin
            seg    = $urandom_range(20, 120);
            steady = ($urandom_range(0, 2) == 0);
            repeat (seg) begin
                @(negedge aclk);
                if (!steady && stall == 0 && $urandom_range(0, 3) == 0) stall = pause_len();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    stall--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata[0], m_tlast);
        end
    end

    // ends the run when neither channel moves for too long
    initial begin
        @(posedge aresetn);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single-column rows: full, empty, peak, ignored neighbors
        send_fixed(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_fixed(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        send_fixed(8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1);
        send_fixed(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b1);
        // top row
        send_fixed(8'hFF, 8'h0A, 8'hC8, 1'b0, 1'b1, 1'b0);
        send_fixed(8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b0);
        send_fixed(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        // bottom row with a flat column whose center is just above the mean
        send_fixed(8'h07, 8'hC8, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_fixed(8'hFF, 8'h01, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_fixed(8'h80, 8'h80, 8'h80, 1'b1, 1'b0, 1'b0);
        send_fixed(8'h00, 8'hFF, 8'h09, 1'b1, 1'b0, 1'b1);
        // row flags changing within one row
        send_fixed(8'h32, 8'h3C, 8'h46, 1'b1, 1'b1, 1'b0);
        send_fixed(8'h32, 8'h3C, 8'h46, 1'b0, 1'b0, 1'b0);
        send_fixed(8'hFF, 8'hFE, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_fixed(8'h00, 8'h01, 8'h00, 1'b0, 1'b1, 1'b0);
        send_fixed(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
        // two-column row
        send_fixed(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
        send_fixed(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1);

        while (sb.slices_taken < SLICE_TARGET) send_random_row();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
